// File: sv/sp_pkg.sv
package sp_pkg;

    localparam int NW = 51;
    localparam int EW = 12;
    localparam int TW = 64;
    localparam int NCOEF = 6;

    typedef logic [31:0] f32_t;
    typedef logic signed [EW-1:0] exp_t;
    typedef logic [NW-1:0] nrm_t;
    typedef logic [TW-1:0] tag_t;

    localparam f32_t SIGN_BIT = 32'h8000_0000;
    localparam f32_t INF_BITS = 32'h7f80_0000;
    localparam f32_t QUIET_BIT = 32'h0040_0000;
    localparam f32_t DEFAULT_NAN = 32'h7fc0_0000;

    localparam f32_t COEF [NCOEF] = '{
        32'h32d2a000, 32'h3638ef1d, 32'h39500ccb,
        32'h3c088887, 32'h3e2aaaab, 32'h3f800000
    };

    // One request into the normalize and round pipeline
    typedef struct packed {
        logic spec;
        f32_t spec_bits;
        logic sign;
        nrm_t n;
        exp_t e_top;
        tag_t tag;
    } rnd_req_t;

    function automatic logic is_nan(input f32_t v);
        return v[30:0] > INF_BITS[30:0];
    endfunction

    function automatic logic is_inf(input f32_t v);
        return v[30:0] == INF_BITS[30:0];
    endfunction

    function automatic logic is_zero(input f32_t v);
        return v[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] mant_of(input f32_t v);
        return (v[30:23] == 8'd0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
    endfunction

    // Weight of the mantissa LSB
    function automatic exp_t exp_of(input f32_t v);
        exp_t e;
        if (v[30:23] == 8'd0)
        begin
            e = -exp_t'(149);
        end
        else
        begin
            e = $signed({4'd0, v[30:23]}) - exp_t'(150);
        end
        return e;
    endfunction

    function automatic logic [5:0] lzc51(input nrm_t v);
        logic [5:0] c;
        c = 6'(NW);
        for (int i = 0; i < NW; i++)
        begin
            if (v[i])
            begin
                c = 6'(NW - 1 - i);
            end
        end
        return c;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] c;
        c = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                c = 6'(47 - i);
            end
        end
        return c;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] c;
        c = 5'd24;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                c = 5'(23 - i);
            end
        end
        return c;
    endfunction

    // nn has its MSB set; be is the biased exponent of that MSB
    function automatic f32_t round_pack(input logic sign, input nrm_t nn, input exp_t be);
        logic [25:0] val;
        logic [25:0] mask;
        logic [25:0] shd;
        logic [4:0] sh;
        logic lost;
        logic up;
        logic big;
        logic [23:0] qn;
        logic [24:0] qr;
        exp_t ex;
        f32_t r;
        val = {nn[50:27], nn[26], |nn[25:0]};
        big = 1'b0;
        sh = 5'd0;
        if (be < exp_t'(1))
        begin
            if (be <= -exp_t'(24))
            begin
                big = 1'b1;
            end
            else
            begin
                sh = 5'(exp_t'(1) - be);
            end
        end
        mask = (26'd1 << sh) - 26'd1;
        shd = val >> sh;
        lost = |(val & mask);
        qn = shd[25:2];
        up = shd[1] & (shd[0] | lost | qn[0]);
        qr = {1'b0, qn} + {24'd0, up};
        ex = qr[24] ? be + exp_t'(1) : be;
        if (big)
        begin
            r = {sign, 31'd0};
        end
        else if (sh != 5'd0)
        begin
            r = {sign, 7'd0, qr[23:0]};
        end
        else if (ex >= exp_t'(255))
        begin
            r = {sign, INF_BITS[30:0]};
        end
        else
        begin
            r = {sign, ex[7:0], qr[24] ? 23'd0 : qr[22:0]};
        end
        return r;
    endfunction

endpackage

// File: sv/sp_round.sv
module sp_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sp_pkg::rnd_req_t  req,
    output logic              out_valid,
    input  logic              out_stall,
    output sp_pkg::f32_t      res,
    output sp_pkg::tag_t      tag_out
);

    logic va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next;
    logic adv_a, adv_b, adv_c;

    sp_pkg::rnd_req_t ra_reg;
    logic [5:0]       lza_reg;

    logic             spb_reg;
    sp_pkg::f32_t     sbb_reg;
    logic             sgb_reg;
    sp_pkg::nrm_t     nb_reg;
    sp_pkg::exp_t     beb_reg;
    sp_pkg::tag_t     tagb_reg;

    sp_pkg::f32_t     res_reg;
    sp_pkg::tag_t     tagc_reg;

    assign adv_c = !vc_reg || !out_stall;
    assign adv_b = !vb_reg || adv_c;
    assign adv_a = !va_reg || adv_b;
    assign in_stall = !adv_a;

    assign va_next = adv_a ? in_valid : va_reg;
    assign vb_next = adv_b ? va_reg : vb_reg;
    assign vc_next = adv_c ? vb_reg : vc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            ra_reg  <= req;
            lza_reg <= sp_pkg::lzc51(req.n);
        end
        if (adv_b)
        begin
            spb_reg  <= ra_reg.spec;
            sbb_reg  <= ra_reg.spec_bits;
            sgb_reg  <= ra_reg.sign;
            nb_reg   <= ra_reg.n << lza_reg;
            beb_reg  <= ra_reg.e_top - $signed({6'd0, lza_reg}) + sp_pkg::exp_t'(127);
            tagb_reg <= ra_reg.tag;
        end
        if (adv_c)
        begin
            res_reg  <= spb_reg ? sbb_reg : sp_pkg::round_pack(sgb_reg, nb_reg, beb_reg);
            tagc_reg <= tagb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign res = res_reg;
    assign tag_out = tagc_reg;

`ifndef SYNTHESIS
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !va_reg |-> !in_stall)
        else $error("round stage stalls with an empty entry stage");

    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        vb_reg && !spb_reg |-> nb_reg[50])
        else $error("mantissa not normalized before rounding");
`endif

endmodule

// File: sv/sp_fmul.sv
module sp_fmul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sp_pkg::f32_t      a,
    input  sp_pkg::f32_t      b,
    input  sp_pkg::tag_t      tag_in,
    output logic              out_valid,
    input  logic              out_stall,
    output sp_pkg::f32_t      res,
    output sp_pkg::tag_t      tag_out
);

    logic v1_reg, v1_next, adv1, rnd_stall;
    sp_pkg::rnd_req_t req1_reg, req1_next;
    logic ps;
    logic [47:0] prod;

    assign adv1 = !v1_reg || !rnd_stall;
    assign in_stall = !adv1;
    assign v1_next = adv1 ? in_valid : v1_reg;

    always_comb
    begin
        ps = a[31] ^ b[31];
        prod = sp_pkg::mant_of(a) * sp_pkg::mant_of(b);
        req1_next.spec = 1'b1;
        req1_next.spec_bits = {ps, 31'd0};
        req1_next.sign = ps;
        req1_next.n = {prod, 3'd0};
        req1_next.e_top = sp_pkg::exp_of(a) + sp_pkg::exp_of(b) + sp_pkg::exp_t'(47);
        req1_next.tag = tag_in;
        if (sp_pkg::is_nan(a))
        begin
            req1_next.spec_bits = a | sp_pkg::QUIET_BIT;
        end
        else if (sp_pkg::is_nan(b))
        begin
            req1_next.spec_bits = b | sp_pkg::QUIET_BIT;
        end
        else if ((sp_pkg::is_inf(a) && sp_pkg::is_zero(b)) ||
                 (sp_pkg::is_inf(b) && sp_pkg::is_zero(a)))
        begin
            req1_next.spec_bits = sp_pkg::DEFAULT_NAN;
        end
        else if (sp_pkg::is_inf(a) || sp_pkg::is_inf(b))
        begin
            req1_next.spec_bits = {ps, sp_pkg::INF_BITS[30:0]};
        end
        else if (sp_pkg::is_zero(a) || sp_pkg::is_zero(b))
        begin
            req1_next.spec_bits = {ps, 31'd0};
        end
        else
        begin
            req1_next.spec = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            req1_reg <= req1_next;
        end
    end

    sp_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .in_stall  (rnd_stall),
        .req       (req1_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res),
        .tag_out   (tag_out)
    );

endmodule

// File: sv/sp_ffma.sv
module sp_ffma (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sp_pkg::f32_t      a,
    input  sp_pkg::f32_t      b,
    input  sp_pkg::f32_t      c,
    input  sp_pkg::tag_t      tag_in,
    output logic              out_valid,
    input  logic              out_stall,
    output sp_pkg::f32_t      res,
    output sp_pkg::tag_t      tag_out
);

    typedef struct packed {
        logic          spec;
        sp_pkg::f32_t  sb;
        logic          ps;
        logic          sc;
        logic          cz;
        logic [47:0]   mp;
        sp_pkg::exp_t  ep;
        logic [23:0]   mc;
        sp_pkg::exp_t  ec;
        sp_pkg::tag_t  tag;
    } fma_s1_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    logic adv1, adv2, adv3, adv4, adv5, rnd_stall;

    fma_s1_t s1_next, s1_reg, s2_reg;
    logic [5:0] lzp2_reg;
    logic [4:0] lzc2_reg;

    logic         spec3_reg, sl3_reg, sub3_reg;
    sp_pkg::f32_t sb3_reg;
    logic [47:0]  l3_reg, s3_reg;
    sp_pkg::exp_t el3_reg, d3_reg;
    sp_pkg::tag_t tag3_reg;

    logic         spec4_reg, sl4_reg, sub4_reg;
    sp_pkg::f32_t sb4_reg;
    sp_pkg::nrm_t a4_reg, b4_reg;
    sp_pkg::exp_t el4_reg;
    sp_pkg::tag_t tag4_reg;

    sp_pkg::rnd_req_t req5_reg, req5_next;

    logic         ps, sc;
    logic [47:0]  p_n, c_n, l3_next, s3_next;
    logic [23:0]  mc_n;
    sp_pkg::exp_t ep_n, ec_n, el3_next, d3_next;
    logic         sl3_next;
    sp_pkg::nrm_t bf, b4_next, sum;
    logic [5:0]   dd;

    assign adv5 = !v5_reg || !rnd_stall;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_stall = !adv1;

    assign v1_next = adv1 ? in_valid : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;
    assign v3_next = adv3 ? v2_reg : v3_reg;
    assign v4_next = adv4 ? v3_reg : v4_reg;
    assign v5_next = adv5 ? v4_reg : v5_reg;

    // Stage 1: operand screening and mantissa product
    always_comb
    begin
        ps = a[31] ^ b[31];
        sc = c[31];
        s1_next.ps = ps;
        s1_next.sc = sc;
        s1_next.cz = sp_pkg::is_zero(c);
        s1_next.mp = sp_pkg::mant_of(a) * sp_pkg::mant_of(b);
        s1_next.ep = sp_pkg::exp_of(a) + sp_pkg::exp_of(b);
        s1_next.mc = sp_pkg::mant_of(c);
        s1_next.ec = sp_pkg::exp_of(c);
        s1_next.tag = tag_in;
        s1_next.spec = 1'b1;
        s1_next.sb = c;
        if (sp_pkg::is_nan(a))
        begin
            s1_next.sb = a | sp_pkg::QUIET_BIT;
        end
        else if (sp_pkg::is_nan(b))
        begin
            s1_next.sb = b | sp_pkg::QUIET_BIT;
        end
        else if (sp_pkg::is_nan(c))
        begin
            s1_next.sb = c | sp_pkg::QUIET_BIT;
        end
        else if ((sp_pkg::is_inf(a) && sp_pkg::is_zero(b)) ||
                 (sp_pkg::is_inf(b) && sp_pkg::is_zero(a)))
        begin
            s1_next.sb = sp_pkg::DEFAULT_NAN;
        end
        else if (sp_pkg::is_inf(a) || sp_pkg::is_inf(b))
        begin
            s1_next.sb = (sp_pkg::is_inf(c) && sc != ps) ? sp_pkg::DEFAULT_NAN
                                                          : {ps, sp_pkg::INF_BITS[30:0]};
        end
        else if (sp_pkg::is_inf(c))
        begin
            s1_next.sb = c;
        end
        else if (sp_pkg::is_zero(a) || sp_pkg::is_zero(b))
        begin
            s1_next.sb = sp_pkg::is_zero(c) ? {ps & sc, 31'd0} : c;
        end
        else
        begin
            s1_next.spec = 1'b0;
        end
    end

    // Stage 3: normalize both terms, order by magnitude
    always_comb
    begin
        p_n  = s2_reg.mp << lzp2_reg;
        ep_n = s2_reg.ep + sp_pkg::exp_t'(47) - $signed({6'd0, lzp2_reg});
        mc_n = s2_reg.mc << lzc2_reg;
        c_n  = {mc_n, 24'd0};
        ec_n = s2_reg.ec + sp_pkg::exp_t'(23) - $signed({7'd0, lzc2_reg});
        if (s2_reg.cz)
        begin
            l3_next = p_n;
            s3_next = 48'd0;
            el3_next = ep_n;
            d3_next = '0;
            sl3_next = s2_reg.ps;
        end
        else if (ep_n > ec_n || (ep_n == ec_n && p_n >= c_n))
        begin
            l3_next = p_n;
            s3_next = c_n;
            el3_next = ep_n;
            d3_next = ep_n - ec_n;
            sl3_next = s2_reg.ps;
        end
        else
        begin
            l3_next = c_n;
            s3_next = p_n;
            el3_next = ec_n;
            d3_next = ec_n - ep_n;
            sl3_next = s2_reg.sc;
        end
    end

    // Stage 4: align the smaller term, fold shifted-out bits into sticky
    always_comb
    begin
        bf = {1'b0, s3_reg, 2'd0};
        dd = d3_reg[5:0];
        if (d3_reg >= sp_pkg::exp_t'(sp_pkg::NW))
        begin
            b4_next = {50'd0, |s3_reg};
        end
        else
        begin
            b4_next = (bf >> dd) | {50'd0, |(bf & ((51'd1 << dd) - 51'd1))};
        end
    end

    // Stage 5: add or subtract
    always_comb
    begin
        sum = sub4_reg ? a4_reg - b4_reg : a4_reg + b4_reg;
        req5_next.spec = spec4_reg;
        req5_next.spec_bits = sb4_reg;
        req5_next.sign = sl4_reg;
        req5_next.n = sum;
        req5_next.e_top = el4_reg + sp_pkg::exp_t'(1);
        req5_next.tag = tag4_reg;
        if (!spec4_reg && sum == '0)
        begin
            req5_next.spec = 1'b1;
            req5_next.spec_bits = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= s1_next;
        end
        if (adv2)
        begin
            s2_reg   <= s1_reg;
            lzp2_reg <= sp_pkg::lzc48(s1_reg.mp);
            lzc2_reg <= sp_pkg::lzc24(s1_reg.mc);
        end
        if (adv3)
        begin
            spec3_reg <= s2_reg.spec;
            sb3_reg   <= s2_reg.sb;
            sl3_reg   <= sl3_next;
            sub3_reg  <= (s2_reg.ps != s2_reg.sc) && !s2_reg.cz;
            l3_reg    <= l3_next;
            s3_reg    <= s3_next;
            el3_reg   <= el3_next;
            d3_reg    <= d3_next;
            tag3_reg  <= s2_reg.tag;
        end
        if (adv4)
        begin
            spec4_reg <= spec3_reg;
            sb4_reg   <= sb3_reg;
            sl4_reg   <= sl3_reg;
            sub4_reg  <= sub3_reg;
            a4_reg    <= {1'b0, l3_reg, 2'd0};
            b4_reg    <= b4_next;
            el4_reg   <= el3_reg;
            tag4_reg  <= tag3_reg;
        end
        if (adv5)
        begin
            req5_reg <= req5_next;
        end
    end

    sp_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_stall  (rnd_stall),
        .req       (req5_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res),
        .tag_out   (tag_out)
    );

`ifndef SYNTHESIS
    a_large_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !spec4_reg |-> a4_reg[49] && !a4_reg[50])
        else $error("larger addend term not normalized");
`endif

endmodule

// File: sv/sine_poly_float32.sv
// Odd polynomial sine on binary32: u = x*x, five fused multiply-adds, then x*r.
// Pipeline: 48 register stages (4 per multiply, 8 per fused multiply-add).
// Throughput: one request per cycle unless a full pipeline is stalled; each stage holds under stall and fills holes.
// Reset: rst_n clears all pipeline valid bits asynchronously; data is not reset.
module sine_poly_float32 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [31:0]  x_bits,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [31:0]  y_bits
);

    logic         v_ch  [0:5];
    logic         st_ch [0:5];
    sp_pkg::f32_t r_ch  [0:5];
    sp_pkg::tag_t t_ch  [0:5];
    sp_pkg::tag_t t0_tag;
    sp_pkg::tag_t t_fin;

    sp_fmul u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a         (x_bits),
        .b         (x_bits),
        .tag_in    ({x_bits, 32'd0}),
        .out_valid (v_ch[0]),
        .out_stall (st_ch[0]),
        .res       (r_ch[0]),
        .tag_out   (t0_tag)
    );

    // Tag carries x in the upper half and u in the lower half
    assign t_ch[0] = {t0_tag[63:32], r_ch[0]};

    for (genvar i = 1; i < sp_pkg::NCOEF; i++)
    begin : g_horner
        // Start the recurrence from the leading coefficient
        sp_ffma u_fma (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_ch[i-1]),
            .in_stall  (st_ch[i-1]),
            .a         (t_ch[i-1][31:0] ^ sp_pkg::SIGN_BIT),
            .b         ((i == 1) ? sp_pkg::COEF[0] : r_ch[i-1]),
            .c         (sp_pkg::COEF[i]),
            .tag_in    (t_ch[i-1]),
            .out_valid (v_ch[i]),
            .out_stall (st_ch[i]),
            .res       (r_ch[i]),
            .tag_out   (t_ch[i])
        );
    end

    sp_fmul u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_ch[5]),
        .in_stall  (st_ch[5]),
        .a         (t_ch[5][63:32]),
        .b         (r_ch[5]),
        .tag_in    (t_ch[5]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (y_bits),
        .tag_out   (t_fin)
    );

`ifndef SYNTHESIS
    a_nan_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sp_pkg::is_nan(t_fin[63:32]) |->
            y_bits == (t_fin[63:32] | sp_pkg::QUIET_BIT))
        else $error("NaN argument not returned quieted");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(y_bits))
        else $error("result has unknown bits");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(y_bits))
        else $error("stalled result changed");
`endif

endmodule

// File: tb/tb_sine_poly_float32.sv
`timescale 1ns / 1ps

module tb_sine_poly_float32;

    typedef sp_pkg::f32_t f32_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] x_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] y_bits;

    f32_t sine_queue[$];
    int   n_errors;
    bit   stall_random;
    bit   hold_recv;
    int   recv_gap_max;
    int   send_gap_max;

    localparam f32_t FSIGN = 32'h8000_0000;
    localparam f32_t FINF = 32'h7f80_0000;
    localparam f32_t FQUIET = 32'h0040_0000;
    localparam f32_t FDNAN = 32'h7fc0_0000;
    localparam int LATENCY = 48;

    localparam f32_t POLY_C [6] = '{
        32'h32d2a000, 32'h3638ef1d, 32'h39500ccb,
        32'h3c088887, 32'h3e2aaaab, 32'h3f800000
    };

    sine_poly_float32 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_bits    (x_bits),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .y_bits    (y_bits)
    );

    always #5 clk = ~clk;

    function automatic bit f_nan(input f32_t v);
        return v[30:0] > FINF[30:0];
    endfunction

    function automatic bit f_inf(input f32_t v);
        return v[30:0] == FINF[30:0];
    endfunction

    function automatic bit f_zero(input f32_t v);
        return v[30:0] == 31'd0;
    endfunction

    function automatic void split(input f32_t v, output longint unsigned m, output int e);
        if (v[30:23] == 8'd0)
        begin
            m = v[22:0];
            e = -149;
        end
        else
        begin
            m = {1'b1, v[22:0]};
            e = int'(v[30:23]) - 150;
        end
    endfunction

    // Round sign * m * 2^e to binary32, nearest-even; LSB of m may be sticky
    function automatic f32_t round_f32(input f32_t sgn, input longint unsigned m, input int e);
        int p;
        int s;
        int bexp;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned half;
        p = 63;
        while (p > 0 && m[p] == 1'b0)
        begin
            p--;
        end
        s = p - 23;
        if (-149 - e > s)
        begin
            s = -149 - e;
        end
        if (s <= 0)
        begin
            q = m << (-s);
        end
        else
        begin
            if (s >= 65)
            begin
                q = 0;
                rem = 0;
                half = 1;
            end
            else if (s == 64)
            begin
                q = 0;
                rem = m;
                half = 64'h8000_0000_0000_0000;
            end
            else
            begin
                q = m >> s;
                rem = m & ((64'd1 << s) - 64'd1);
                half = 64'd1 << (s - 1);
            end
            if (rem > half || (rem == half && q[0]))
            begin
                q++;
            end
            if (q == (64'd1 << 24))
            begin
                q >>= 1;
                s++;
            end
        end
        if (q >= (64'd1 << 23))
        begin
            bexp = e + s + 150;
            if (bexp >= 255)
            begin
                return sgn | FINF;
            end
            return sgn | (f32_t'(bexp) << 23) | (f32_t'(q) & 32'h007f_ffff);
        end
        return sgn | f32_t'(q);
    endfunction

    function automatic f32_t mul_f32(input f32_t a, input f32_t b);
        f32_t ps;
        longint unsigned ma;
        longint unsigned mb;
        int ea;
        int eb;
        ps = (a ^ b) & FSIGN;
        if (f_nan(a))
        begin
            return a | FQUIET;
        end
        if (f_nan(b))
        begin
            return b | FQUIET;
        end
        if ((f_inf(a) && f_zero(b)) || (f_inf(b) && f_zero(a)))
        begin
            return FDNAN;
        end
        if (f_inf(a) || f_inf(b))
        begin
            return ps | FINF;
        end
        if (f_zero(a) || f_zero(b))
        begin
            return ps;
        end
        split(a, ma, ea);
        split(b, mb, eb);
        return round_f32(ps, ma * mb, ea + eb);
    endfunction

    function automatic f32_t fma_f32(input f32_t a, input f32_t b, input f32_t c);
        f32_t ps;
        f32_t sc;
        f32_t sl;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mp;
        longint unsigned mc;
        longint unsigned ml;
        longint unsigned msm;
        longint unsigned sum;
        longint unsigned lost;
        int ea;
        int eb;
        int ep;
        int ec;
        int el;
        int esm;
        int d;
        ps = (a ^ b) & FSIGN;
        sc = c & FSIGN;
        if (f_nan(a))
        begin
            return a | FQUIET;
        end
        if (f_nan(b))
        begin
            return b | FQUIET;
        end
        if (f_nan(c))
        begin
            return c | FQUIET;
        end
        if ((f_inf(a) && f_zero(b)) || (f_inf(b) && f_zero(a)))
        begin
            return FDNAN;
        end
        if (f_inf(a) || f_inf(b))
        begin
            if (f_inf(c) && sc != ps)
            begin
                return FDNAN;
            end
            return ps | FINF;
        end
        if (f_inf(c))
        begin
            return c;
        end
        if (f_zero(a) || f_zero(b))
        begin
            if (f_zero(c))
            begin
                return ps & sc;
            end
            return c;
        end
        split(a, ma, ea);
        split(b, mb, eb);
        mp = ma * mb;
        ep = ea + eb;
        if (f_zero(c))
        begin
            return round_f32(ps, mp, ep);
        end
        split(c, mc, ec);
        while ((mp >> 61) == 0)
        begin
            mp <<= 1;
            ep--;
        end
        while ((mc >> 61) == 0)
        begin
            mc <<= 1;
            ec--;
        end
        if (ep > ec || (ep == ec && mp >= mc))
        begin
            ml = mp;
            el = ep;
            sl = ps;
            msm = mc;
            esm = ec;
        end
        else
        begin
            ml = mc;
            el = ec;
            sl = sc;
            msm = mp;
            esm = ep;
        end
        d = el - esm;
        if (d >= 63)
        begin
            msm = 1;
        end
        else
        begin
            lost = msm & ((64'd1 << d) - 64'd1);
            msm = (msm >> d) | ((lost != 0) ? 64'd1 : 64'd0);
        end
        if (ps == sc)
        begin
            sum = ml + msm;
        end
        else
        begin
            sum = ml - msm;
            if (sum == 0)
            begin
                return 32'd0;
            end
        end
        return round_f32(sl, sum, el);
    endfunction

    function automatic f32_t predict_sine(input f32_t x);
        f32_t u;
        f32_t r;
        u = mul_f32(x, x);
        r = POLY_C[0];
        for (int i = 1; i < 6; i++)
        begin
            r = fma_f32(u ^ FSIGN, r, POLY_C[i]);
        end
        return mul_f32(x, r);
    endfunction

    // Entered at a falling edge; leaves valid up so the next request can follow at once
    task automatic send_request(input f32_t x);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            x_bits   <= $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        x_bits   <= x;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sine_queue.push_back(predict_sine(x));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        x_bits   <= $urandom;
        while (sine_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (sine_queue.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, y_bits);
                n_errors++;
            end
            else
            begin
                if (y_bits !== sine_queue[0])
                begin
                    $display("%0t: y_bits expected %h actual %h",
                             $time, sine_queue[0], y_bits);
                    n_errors++;
                end
                void'(sine_queue.pop_front());
            end
        end
    end

    // Receiver stall: random per result, or a long hold
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_recv)
            begin
                out_stall <= 1'b1;
                repeat (200) @(negedge clk);
                out_stall <= 1'b0;
                hold_recv = 1'b0;
            end
            else if (stall_random)
            begin
                gap = $urandom_range(0, recv_gap_max);
                if (gap != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap - 1) @(negedge clk);
                    @(negedge clk);
                end
                out_stall <= 1'b0;
                while (!(out_valid && !out_stall))
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic f32_t random_arg();
        int sel;
        f32_t v;
        sel = $urandom_range(0, 9);
        v = $urandom;
        case (sel)
            0, 1, 2, 3, 4: v[30:23] = 8'($urandom_range(100, 127));
            5: v[30:23] = 8'($urandom_range(0, 40));
            6: v[30:23] = 8'($urandom_range(128, 160));
            7: v[30:23] = 8'hff;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        f32_t vals[$];
        vals = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001,
                 32'h007f_ffff, 32'h0080_0000, 32'h3f80_0000, 32'hbf80_0000,
                 32'h3fc9_0fdb, 32'hbfc9_0fdb, 32'h3f00_0000, 32'h4049_0fdb,
                 32'h7f7f_ffff, 32'hff7f_ffff, 32'h7f80_0000, 32'hff80_0000,
                 32'h7fc0_0000, 32'h7f80_0001, 32'hffbf_ffff, 32'h1f80_0000,
                 32'h2000_0000, 32'h5f80_0000, 32'h4300_0000, 32'hffff_ffff};
        foreach (vals[i])
        begin
            send_request(vals[i]);
        end
        wait_drained();
    endtask

    task automatic test_back_to_back();
        send_gap_max = 0;
        stall_random = 1'b0;
        repeat (60) send_request(random_arg());
        wait_drained();
    endtask

    task automatic test_random_idle();
        send_gap_max = 10;
        recv_gap_max = 10;
        stall_random = 1'b1;
        repeat (250) send_request(random_arg());
        stall_random = 1'b0;
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_gap_max = 0;
        hold_recv = 1'b1;
        repeat (90) send_request(random_arg());
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_bits = 32'd0;
        n_errors = 0;
        stall_random = 1'b0;
        hold_recv = 1'b0;
        recv_gap_max = 0;
        send_gap_max = 3;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_back_to_back();
        test_random_idle();
        test_backpressure();
        if (n_errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
